[rtl/tbg_pkg.sv]
// Shared types and constants for the tangent basis generator.
`default_nettype none
package tbg_pkg;

  // Field and datapath widths.
  localparam int CW   = 16;     // input and output components
  localparam int DW   = 17;     // edge and texture deltas
  localparam int AW   = 35;     // multiplier operand A
  localparam int BW   = 17;     // multiplier operand B
  localparam int PW   = AW + BW;
  localparam int RW   = 36;     // raw tangent and bitangent
  localparam int VW   = 50;     // normaliser input components
  localparam int SW   = 33;     // dot and cross product terms
  localparam int QDEPTH = 2;    // triangle queue depth
  localparam int QPW  = 1;      // queue pointer width

  // Unit magnitude, 1.0 in Q1.14, the largest a normalised component may reach.
  localparam logic [14:0] UNIT = 15'd16384;

  // One complete triangle, as handed from the front to the back.
  typedef struct packed {
    logic [2:0][DW-1:0] e1;
    logic [2:0][DW-1:0] e2;
    logic [DW-1:0]      d1u;
    logic [DW-1:0]      d1v;
    logic [DW-1:0]      d2u;
    logic [DW-1:0]      d2v;
    logic [2:0][CW-1:0] n0;
    logic [2:0][CW-1:0] n1;
    logic [2:0][CW-1:0] n2;
  } tri_t;

  // Normaliser status towards the back.
  typedef struct packed {
    logic done;
    logic ok;
  } nstat_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_DET, BS_RAW, BS_NT, BS_NB, BS_DOT, BS_W, BS_NW, BS_CROSS, BS_H, BS_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    NS_IDLE, NS_SHIFT, NS_SQ, NS_SQRT, NS_DIV
  } norm_state_t;

endpackage
`default_nettype wire

[rtl/tbg_front.sv]
// Front end: takes vertices, holds the first two corners and forms triangle deltas.
`default_nettype none
module tbg_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [tbg_pkg::CW-1:0]    pos_x,
  input  wire logic [tbg_pkg::CW-1:0]    pos_y,
  input  wire logic [tbg_pkg::CW-1:0]    pos_z,
  input  wire logic [tbg_pkg::CW-1:0]    tex_u,
  input  wire logic [tbg_pkg::CW-1:0]    tex_v,
  input  wire logic [tbg_pkg::CW-1:0]    norm_x,
  input  wire logic [tbg_pkg::CW-1:0]    norm_y,
  input  wire logic [tbg_pkg::CW-1:0]    norm_z,
  input  wire logic                      full,
  output logic                           push,
  output tbg_pkg::tri_t                  push_data
);

  logic [1:0] corner_index;
  logic [1:0][2:0][tbg_pkg::CW-1:0] held_position;
  logic [1:0][1:0][tbg_pkg::CW-1:0] held_texcoord;
  logic [1:0][2:0][tbg_pkg::CW-1:0] held_normal;
  logic [2:0][tbg_pkg::CW-1:0] pin;
  logic accept;
  logic closing;

  assign pin = {pos_z, pos_y, pos_x};

  // The closing corner waits only when the queue has no room.
  assign closing  = (corner_index >= 2'd2);
  assign in_stall = closing && full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && closing;

  // Corner counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_index <= 2'd0;
    end else if (accept) begin
      corner_index <= closing ? 2'd0 : corner_index + 2'd1;
    end
  end

  // Held corners need no reset: each is written before the triangle closes.
  always_ff @(posedge clk) begin
    if (accept && !closing) begin
      held_position[corner_index[0]] <= pin;
      held_texcoord[corner_index[0]] <= {tex_v, tex_u};
      held_normal[corner_index[0]]   <= {norm_z, norm_y, norm_x};
    end
  end

  // Edge and texture-coordinate deltas of the closing triangle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data.e1[i] = tbg_pkg::DW'($signed(held_position[1][i]))
                      - tbg_pkg::DW'($signed(held_position[0][i]));
      push_data.e2[i] = tbg_pkg::DW'($signed(pin[i]))
                      - tbg_pkg::DW'($signed(held_position[0][i]));
    end
    push_data.d1u = tbg_pkg::DW'($signed(held_texcoord[1][0]))
                  - tbg_pkg::DW'($signed(held_texcoord[0][0]));
    push_data.d1v = tbg_pkg::DW'($signed(held_texcoord[1][1]))
                  - tbg_pkg::DW'($signed(held_texcoord[0][1]));
    push_data.d2u = tbg_pkg::DW'($signed(tex_u))
                  - tbg_pkg::DW'($signed(held_texcoord[0][0]));
    push_data.d2v = tbg_pkg::DW'($signed(tex_v))
                  - tbg_pkg::DW'($signed(held_texcoord[0][1]));
    push_data.n0 = held_normal[0];
    push_data.n1 = held_normal[1];
    push_data.n2 = {norm_z, norm_y, norm_x};
  end

  // The input only ever waits on the closing corner.
  a_stall_on_close: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> corner_index >= 2'd2)
    else $error("front stalled on an opening corner");

endmodule
`default_nettype wire

[rtl/tbg_fifo.sv]
// Short triangle queue between the front and the back.
`default_nettype none
module tbg_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire tbg_pkg::tri_t   wdata,
  output logic                 full,
  input  wire logic            rd,
  output tbg_pkg::tri_t        rdata,
  output logic                 nempty
);

  tbg_pkg::tri_t entry [tbg_pkg::QDEPTH];
  logic [tbg_pkg::QPW-1:0] wp;
  logic [tbg_pkg::QPW-1:0] rp;
  logic [tbg_pkg::QPW:0]   cnt;

  assign full   = (cnt == (tbg_pkg::QPW+1)'(tbg_pkg::QDEPTH));
  assign nempty = (cnt != '0);
  assign rdata  = entry[rp];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (tbg_pkg::QPW+1)'(wr) - (tbg_pkg::QPW+1)'(rd);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wp] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> cnt < (tbg_pkg::QPW+1)'(tbg_pkg::QDEPTH))
    else $error("triangle queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> cnt != '0)
    else $error("triangle queue read while empty");

endmodule
`default_nettype wire

[rtl/tbg_norm.sv]
// Iterative vector normaliser: scale, square root and per-component division.
`default_nettype none
module tbg_norm (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [2:0][tbg_pkg::VW-1:0]  vin,
  output logic [2:0][tbg_pkg::CW-1:0]       vout,
  output tbg_pkg::nstat_t                   stat
);

  tbg_pkg::norm_state_t st;
  logic [2:0][tbg_pkg::VW-1:0] m;
  logic [2:0] neg;
  logic [59:0] sq;
  logic [61:0] sum;
  logic [63:0] x;
  logic [63:0] r;
  logic [4:0]  cnt;
  logic [1:0]  k;
  logic        dini;
  logic [14:0] nlow;
  logic [14:0] q;
  logic [30:0] rem;
  logic        done;
  logic        ok;

  logic [tbg_pkg::VW-1:0] orm;
  logic [tbg_pkg::VW-1:0] msel;
  logic [63:0] bitv;
  logic [63:0] strial;
  logic [44:0] numi;
  logic [31:0] dtrial;
  logic        dge;
  logic [14:0] qn;
  logic [14:0] qc;
  logic [30:0] len;

  assign stat = '{done: done, ok: ok};
  assign len  = r[30:0];

  // Datapath helpers for each step.
  always_comb begin
    orm = m[0] | m[1] | m[2];
    case (k)
      2'd1:    msel = m[1];
      2'd2:    msel = m[2];
      default: msel = m[0];
    endcase
    bitv   = 64'd1 << {cnt, 1'b0};
    strial = r + bitv;
    numi   = 45'({msel[29:0], 14'd0}) + 45'(len[30:1]);
    dtrial = {rem, nlow[14]};
    dge    = (dtrial >= {1'b0, len});
    qn     = {q[13:0], dge};
    qc     = (qn > tbg_pkg::UNIT) ? tbg_pkg::UNIT : qn;
  end

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= tbg_pkg::NS_IDLE;
      done <= 1'b0;
      ok   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        tbg_pkg::NS_IDLE: begin
          if (go) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vin[i][tbg_pkg::VW-1];
              m[i]   <= vin[i][tbg_pkg::VW-1] ? (tbg_pkg::VW'(0) - vin[i]) : vin[i];
            end
            st <= tbg_pkg::NS_SHIFT;
          end
        end
        tbg_pkg::NS_SHIFT: begin
          // Bring the largest magnitude into [2^29, 2^30) one bit a cycle.
          if (orm == '0) begin
            vout <= '0;
            ok   <= 1'b0;
            done <= 1'b1;
            st   <= tbg_pkg::NS_IDLE;
          end else if (orm[tbg_pkg::VW-1:30] != '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (!orm[29]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            k   <= 2'd0;
            sum <= '0;
            st  <= tbg_pkg::NS_SQ;
          end
        end
        tbg_pkg::NS_SQ: begin
          // Square one component a cycle and add the previous square.
          if (k != 2'd3) begin
            sq <= 60'(msel[29:0]) * 60'(msel[29:0]);
          end
          if (k != 2'd0) begin
            sum <= sum + 62'(sq);
          end
          if (k == 2'd3) begin
            x   <= 64'(sum) + 64'(sq);
            r   <= '0;
            cnt <= 5'd31;
            st  <= tbg_pkg::NS_SQRT;
          end
          k <= k + 2'd1;
        end
        tbg_pkg::NS_SQRT: begin
          // Integer square root, one result bit a cycle.
          if (x >= strial) begin
            x <= x - strial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          if (cnt == 5'd0) begin
            k    <= 2'd0;
            dini <= 1'b1;
            st   <= tbg_pkg::NS_DIV;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        tbg_pkg::NS_DIV: begin
          // Rounded component over length, restoring division a bit a cycle.
          if (dini) begin
            rem  <= {1'b0, numi[44:15]};
            nlow <= numi[14:0];
            q    <= '0;
            cnt  <= 5'd14;
            dini <= 1'b0;
          end else begin
            rem  <= dge ? 31'(dtrial - {1'b0, len}) : dtrial[30:0];
            q    <= qn;
            nlow <= nlow << 1;
            if (cnt == 5'd0) begin
              vout[k] <= neg[k] ? (16'd0 - {1'b0, qc}) : {1'b0, qc};
              if (k == 2'd2) begin
                ok   <= (len != '0);
                done <= 1'b1;
                st   <= tbg_pkg::NS_IDLE;
              end else begin
                k    <= k + 2'd1;
                dini <= 1'b1;
              end
            end else begin
              cnt <= cnt - 5'd1;
            end
          end
        end
        default: st <= tbg_pkg::NS_IDLE;
      endcase
    end
  end

  // A normalised vector never exceeds unit magnitude in any component.
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(vout[0]) <= 16'sd16384 && $signed(vout[0]) >= -16'sd16384 &&
              $signed(vout[1]) <= 16'sd16384 && $signed(vout[1]) >= -16'sd16384 &&
              $signed(vout[2]) <= 16'sd16384 && $signed(vout[2]) >= -16'sd16384))
    else $error("normaliser result out of range");

endmodule
`default_nettype wire

[rtl/tbg_back.sv]
// Back end: per-triangle tangent, bitangent and per-vertex orthogonalisation.
`default_nettype none
module tbg_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_nempty,
  input  wire tbg_pkg::tri_t          q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [tbg_pkg::CW-1:0]      tan_x,
  output logic [tbg_pkg::CW-1:0]      tan_y,
  output logic [tbg_pkg::CW-1:0]      tan_z,
  output logic [tbg_pkg::CW-1:0]      bitan_x,
  output logic [tbg_pkg::CW-1:0]      bitan_y,
  output logic [tbg_pkg::CW-1:0]      bitan_z,
  output logic                        degenerate,
  output logic                        last_of_triangle
);

  tbg_pkg::back_state_t st;
  tbg_pkg::tri_t tr;
  logic        ph;
  logic        op;
  logic [1:0]  vi;
  logic        rb;
  logic [1:0]  k;
  logic signed [tbg_pkg::PW-1:0] prod;
  logic signed [63:0] acc;
  logic        sneg;
  logic        detnz;
  logic        okt;
  logic        degall;
  logic        degk;
  logic        flip;
  logic        nl;
  logic [1:0][2:0][tbg_pkg::RW-1:0] raw;
  logic [2:0][tbg_pkg::CW-1:0] tn;
  logic [2:0][tbg_pkg::CW-1:0] bn;
  logic [2:0][tbg_pkg::CW-1:0] t;
  logic signed [tbg_pkg::SW-1:0] d;
  logic [2:0][tbg_pkg::SW-1:0] c;
  logic [2:0][tbg_pkg::VW-1:0] w;

  logic signed [tbg_pkg::AW-1:0] ma;
  logic signed [tbg_pkg::BW-1:0] mb;
  logic        mneg;
  logic signed [63:0] acc_base;
  logic signed [63:0] acc_sum;
  logic [2:0][tbg_pkg::CW-1:0] nk;
  logic        ngo;
  logic [2:0][tbg_pkg::VW-1:0] nvin;
  logic [2:0][tbg_pkg::CW-1:0] nvout;
  tbg_pkg::nstat_t nstat;
  logic        oload;

  tbg_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .go   (ngo),
    .vin  (nvin),
    .vout (nvout),
    .stat (nstat)
  );

  assign q_pop = (st == tbg_pkg::BS_IDLE) && q_nempty;
  assign oload = (st == tbg_pkg::BS_EMIT) && (!out_valid || !out_stall);
  assign ngo   = !nl && (st == tbg_pkg::BS_NT || st == tbg_pkg::BS_NB ||
                         st == tbg_pkg::BS_NW);

  // Normal of the vertex being finished, and the normaliser input.
  always_comb begin
    case (k)
      2'd1:    nk = tr.n1;
      2'd2:    nk = tr.n2;
      default: nk = tr.n0;
    endcase
    for (int i = 0; i < 3; i++) begin
      case (st)
        tbg_pkg::BS_NT: nvin[i] = tbg_pkg::VW'($signed(raw[0][i]));
        tbg_pkg::BS_NB: nvin[i] = tbg_pkg::VW'($signed(raw[1][i]));
        default:        nvin[i] = w[i];
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma       = '0;
    mb       = '0;
    mneg     = op;
    acc_base = (op == 1'b0) ? 64'sd0 : acc;
    unique case (st)
      tbg_pkg::BS_DET: begin
        ma = tbg_pkg::AW'($signed(op ? tr.d1v : tr.d1u));
        mb = $signed(op ? tr.d2u : tr.d2v);
      end
      tbg_pkg::BS_RAW: begin
        if (!rb) begin
          ma = tbg_pkg::AW'($signed(op ? tr.e2[vi] : tr.e1[vi]));
          mb = $signed(op ? tr.d1v : tr.d2v);
        end else begin
          ma = tbg_pkg::AW'($signed(op ? tr.e1[vi] : tr.e2[vi]));
          mb = $signed(op ? tr.d2u : tr.d1u);
        end
      end
      tbg_pkg::BS_DOT: begin
        ma       = tbg_pkg::AW'($signed(nk[vi]));
        mb       = tbg_pkg::BW'($signed(tn[vi]));
        mneg     = 1'b0;
        acc_base = (vi == 2'd0) ? 64'sd0 : acc;
      end
      tbg_pkg::BS_W: begin
        ma       = tbg_pkg::AW'(d);
        mb       = tbg_pkg::BW'($signed(nk[vi]));
        mneg     = 1'b1;
        acc_base = 64'($signed(tn[vi])) <<< 28;
      end
      tbg_pkg::BS_CROSS: begin
        // c = n x t, component by component.
        case (vi)
          2'd0: begin
            ma = tbg_pkg::AW'($signed(op ? nk[2] : nk[1]));
            mb = tbg_pkg::BW'($signed(op ? t[1] : t[2]));
          end
          2'd1: begin
            ma = tbg_pkg::AW'($signed(op ? nk[0] : nk[2]));
            mb = tbg_pkg::BW'($signed(op ? t[2] : t[0]));
          end
          default: begin
            ma = tbg_pkg::AW'($signed(op ? nk[1] : nk[0]));
            mb = tbg_pkg::BW'($signed(op ? t[0] : t[1]));
          end
        endcase
      end
      tbg_pkg::BS_H: begin
        ma       = tbg_pkg::AW'($signed(c[vi]));
        mb       = tbg_pkg::BW'($signed(bn[vi]));
        mneg     = 1'b0;
        acc_base = (vi == 2'd0) ? 64'sd0 : acc;
      end
      default: begin
        mneg = 1'b0;
      end
    endcase
    acc_sum = acc_base + (mneg ? -64'(prod) : 64'(prod));
  end

  // Triangle sequencer: multiply phase, then accumulate phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= tbg_pkg::BS_IDLE;
      nl <= 1'b0;
    end else begin
      if (ngo) begin
        nl <= 1'b1;
      end else if (nstat.done) begin
        nl <= 1'b0;
      end
      if (!ph) begin
        prod <= tbg_pkg::PW'(ma * mb);
      end
      unique case (st)
        tbg_pkg::BS_IDLE: begin
          if (q_nempty) begin
            tr     <= q_data;
            ph     <= 1'b0;
            op     <= 1'b0;
            vi     <= 2'd0;
            rb     <= 1'b0;
            degall <= 1'b0;
            st     <= tbg_pkg::BS_DET;
          end
        end
        tbg_pkg::BS_DET: begin
          ph <= !ph;
          if (ph) begin
            acc <= acc_sum;
            op  <= !op;
            if (op) begin
              sneg  <= acc_sum < 0;
              detnz <= acc_sum != 0;
              st    <= tbg_pkg::BS_RAW;
            end
          end
        end
        tbg_pkg::BS_RAW: begin
          ph <= !ph;
          if (ph) begin
            acc <= acc_sum;
            op  <= !op;
            if (op) begin
              raw[rb][vi] <= tbg_pkg::RW'(sneg ? -acc_sum : acc_sum);
              if (vi == 2'd2) begin
                vi <= 2'd0;
                if (rb) begin
                  st <= tbg_pkg::BS_NT;
                end else begin
                  rb <= 1'b1;
                end
              end else begin
                vi <= vi + 2'd1;
              end
            end
          end
        end
        tbg_pkg::BS_NT: begin
          if (nstat.done) begin
            tn  <= nvout;
            okt <= nstat.ok;
            st  <= tbg_pkg::BS_NB;
          end
        end
        tbg_pkg::BS_NB: begin
          if (nstat.done) begin
            bn <= nvout;
            k  <= 2'd0;
            vi <= 2'd0;
            op <= 1'b0;
            if (!(detnz && okt && nstat.ok)) begin
              degall <= 1'b1;
              degk   <= 1'b1;
              st     <= tbg_pkg::BS_EMIT;
            end else begin
              st <= tbg_pkg::BS_DOT;
            end
          end
        end
        tbg_pkg::BS_DOT: begin
          ph <= !ph;
          if (ph) begin
            acc <= acc_sum;
            if (vi == 2'd2) begin
              d  <= tbg_pkg::SW'(acc_sum);
              vi <= 2'd0;
              st <= tbg_pkg::BS_W;
            end else begin
              vi <= vi + 2'd1;
            end
          end
        end
        tbg_pkg::BS_W: begin
          ph <= !ph;
          if (ph) begin
            w[vi] <= tbg_pkg::VW'(acc_sum);
            if (vi == 2'd2) begin
              vi <= 2'd0;
              st <= tbg_pkg::BS_NW;
            end else begin
              vi <= vi + 2'd1;
            end
          end
        end
        tbg_pkg::BS_NW: begin
          if (nstat.done) begin
            t  <= nvout;
            op <= 1'b0;
            if (!nstat.ok) begin
              degk <= 1'b1;
              st   <= tbg_pkg::BS_EMIT;
            end else begin
              degk <= 1'b0;
              st   <= tbg_pkg::BS_CROSS;
            end
          end
        end
        tbg_pkg::BS_CROSS: begin
          ph <= !ph;
          if (ph) begin
            acc <= acc_sum;
            op  <= !op;
            if (op) begin
              c[vi] <= tbg_pkg::SW'(acc_sum);
              if (vi == 2'd2) begin
                vi <= 2'd0;
                st <= tbg_pkg::BS_H;
              end else begin
                vi <= vi + 2'd1;
              end
            end
          end
        end
        tbg_pkg::BS_H: begin
          ph <= !ph;
          if (ph) begin
            acc <= acc_sum;
            if (vi == 2'd2) begin
              flip <= acc_sum < 0;
              vi   <= 2'd0;
              st   <= tbg_pkg::BS_EMIT;
            end else begin
              vi <= vi + 2'd1;
            end
          end
        end
        tbg_pkg::BS_EMIT: begin
          if (oload) begin
            if (k == 2'd2) begin
              st <= tbg_pkg::BS_IDLE;
            end else begin
              k <= k + 2'd1;
              if (!degall) begin
                st <= tbg_pkg::BS_DOT;
              end
            end
          end
        end
        default: st <= tbg_pkg::BS_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (oload) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (oload) begin
      tan_x   <= degk ? '0 : (flip ? 16'd0 - t[0] : t[0]);
      tan_y   <= degk ? '0 : (flip ? 16'd0 - t[1] : t[1]);
      tan_z   <= degk ? '0 : (flip ? 16'd0 - t[2] : t[2]);
      bitan_x <= degk ? '0 : bn[0];
      bitan_y <= degk ? '0 : bn[1];
      bitan_z <= degk ? '0 : bn[2];
      degenerate       <= degk;
      last_of_triangle <= (k == 2'd2);
    end
  end

  // A degenerate result always carries zero vectors.
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> tan_x == '0 && tan_y == '0 && tan_z == '0 &&
                                bitan_x == '0 && bitan_y == '0 && bitan_z == '0)
    else $error("degenerate result with non-zero vectors");

  // A triangle is only taken when the sequencer is free.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> st == tbg_pkg::BS_DET)
    else $error("triangle taken without starting the determinant");

endmodule
`default_nettype wire

[rtl/tangent_basis_generator.sv]
// Top level of the tangent basis generator: front, triangle queue and back.
//
//   channel  direction  handshake            payload
//   in       into block in_valid / in_stall  pos_x/y/z, tex_u/v, norm_x/y/z
//   out      from block out_valid / out_stall tan_x/y/z, bitan_x/y/z, degenerate,
//                                             last_of_triangle
//
// The front takes a vertex in every cycle; only the closing corner of a triangle
// waits, and only while the two-entry triangle queue is full.
// The back takes one triangle at a time and relies on the shared normaliser:
// a one-bit-a-cycle 32-step square root and a 15-step division per component,
// run for the tangent and bitangent, then once per vertex unless the triangle is degenerate.
// Reset is synchronous and clears the corner counter, the queue and both sequencers.
// A stalled result stays in the output register while the back works on up to its next result.
`default_nettype none
module tangent_basis_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [15:0] pos_z,
  input  wire logic [15:0] tex_u,
  input  wire logic [15:0] tex_v,
  input  wire logic [15:0] norm_x,
  input  wire logic [15:0] norm_y,
  input  wire logic [15:0] norm_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      tan_x,
  output logic [15:0]      tan_y,
  output logic [15:0]      tan_z,
  output logic [15:0]      bitan_x,
  output logic [15:0]      bitan_y,
  output logic [15:0]      bitan_z,
  output logic             degenerate,
  output logic             last_of_triangle
);

  logic          push;
  logic          full;
  logic          pop;
  logic          nempty;
  tbg_pkg::tri_t push_data;
  tbg_pkg::tri_t pop_data;

  tbg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .tex_u     (tex_u),
    .tex_v     (tex_v),
    .norm_x    (norm_x),
    .norm_y    (norm_y),
    .norm_z    (norm_z),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  tbg_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (push),
    .wdata  (push_data),
    .full   (full),
    .rd     (pop),
    .rdata  (pop_data),
    .nempty (nempty)
  );

  tbg_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_nempty         (nempty),
    .q_data           (pop_data),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .tan_x            (tan_x),
    .tan_y            (tan_y),
    .tan_z            (tan_z),
    .bitan_x          (bitan_x),
    .bitan_y          (bitan_y),
    .bitan_z          (bitan_z),
    .degenerate       (degenerate),
    .last_of_triangle (last_of_triangle)
  );

endmodule
`default_nettype wire

[tb/sv/tangent_basis_checker.sv]
// Checker for the tangent basis generator: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module tangent_basis_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [15:0] pos_z,
  input  wire logic [15:0] tex_u,
  input  wire logic [15:0] tex_v,
  input  wire logic [15:0] norm_x,
  input  wire logic [15:0] norm_y,
  input  wire logic [15:0] norm_z,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] tan_x,
  input  wire logic [15:0] tan_y,
  input  wire logic [15:0] tan_z,
  input  wire logic [15:0] bitan_x,
  input  wire logic [15:0] bitan_y,
  input  wire logic [15:0] bitan_z,
  input  wire logic        degenerate,
  input  wire logic        last_of_triangle,
  output int               fail_count,
  output int               pending,
  output int               basis_count
);

  typedef struct packed {
    logic [15:0] tx, ty, tz;
    logic [15:0] bx, by, bz;
    logic        deg;
    logic        last;
  } basis_t;

  typedef longint vec3_t[3];

  basis_t expected_bases[$];

  // Copy of the first two corners of the triangle being gathered.
  longint corner_pos[2][3];
  longint corner_uv[2][2];
  longint corner_nrm[2][3];
  int     corner_idx;

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scales a vector to Q1.14 unit length; zero vectors give zero and false.
  function automatic bit unit_vector(input vec3_t v, output vec3_t o);
    longint unsigned m[3];
    longint unsigned mx, sum, len, q;
    int i, bits;
    mx = 0;
    sum = 0;
    bits = 0;
    for (i = 0; i < 3; i++) begin
      o[i] = 0;
      m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while (bits < 64 && (mx >> bits) != 0) bits++;
    for (i = 0; i < 3; i++) begin
      if (bits > 30) m[i] = m[i] >> (bits - 30);
      else m[i] = m[i] << (30 - bits);
      sum = sum + m[i] * m[i];
    end
    len = int_sqrt(sum);
    if (len == 0) return 0;
    for (i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + len / 2) / len;
      if (q > 16384) q = 16384;
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic basis_t pack_basis(input vec3_t t, input vec3_t b, input bit deg,
                                        input bit last);
    basis_t r;
    r.tx = t[0][15:0]; r.ty = t[1][15:0]; r.tz = t[2][15:0];
    r.bx = b[0][15:0]; r.by = b[1][15:0]; r.bz = b[2][15:0];
    r.deg = deg;
    r.last = last;
    return r;
  endfunction

  // Works out the three bases of a completed triangle and queues them.
  task automatic predict_triangle(input longint p[3], input longint uv[2],
                                  input longint nrm[3]);
    longint nk[3][3];
    vec3_t traw, braw, tn, bn, w, t, zv;
    longint e1, e2, d1u, d1v, d2u, d2v, det, s, d, h, c0, c1, c2;
    bit ok;
    int i, k;
    for (i = 0; i < 3; i++) begin
      nk[0][i] = corner_nrm[0][i];
      nk[1][i] = corner_nrm[1][i];
      nk[2][i] = nrm[i];
      zv[i] = 0;
    end
    d1u = corner_uv[1][0] - corner_uv[0][0];
    d1v = corner_uv[1][1] - corner_uv[0][1];
    d2u = uv[0] - corner_uv[0][0];
    d2v = uv[1] - corner_uv[0][1];
    det = d1u * d2v - d1v * d2u;
    s = (det < 0) ? -1 : 1;
    for (i = 0; i < 3; i++) begin
      e1 = corner_pos[1][i] - corner_pos[0][i];
      e2 = p[i] - corner_pos[0][i];
      traw[i] = s * (d2v * e1 - d1v * e2);
      braw[i] = s * (d1u * e2 - d2u * e1);
    end
    ok = (det != 0);
    ok = unit_vector(traw, tn) && ok;
    ok = unit_vector(braw, bn) && ok;
    for (k = 0; k < 3; k++) begin
      if (!ok) begin
        expected_bases = {expected_bases, pack_basis(zv, zv, 1'b1, k == 2)};
      end else begin
        d = 0;
        for (i = 0; i < 3; i++) d = d + nk[k][i] * tn[i];
        for (i = 0; i < 3; i++) w[i] = tn[i] * (64'sd1 <<< 28) - nk[k][i] * d;
        if (!unit_vector(w, t)) begin
          expected_bases = {expected_bases, pack_basis(zv, zv, 1'b1, k == 2)};
        end else begin
          c0 = nk[k][1] * t[2] - nk[k][2] * t[1];
          c1 = nk[k][2] * t[0] - nk[k][0] * t[2];
          c2 = nk[k][0] * t[1] - nk[k][1] * t[0];
          h = c0 * bn[0] + c1 * bn[1] + c2 * bn[2];
          if (h < 0) for (i = 0; i < 3; i++) t[i] = -t[i];
          expected_bases = {expected_bases, pack_basis(t, bn, 1'b0, k == 2)};
        end
      end
    end
  endtask

  assign pending = expected_bases.size();

  // Input transfers: hold the first two corners, predict on the third.
  always @(posedge clk) begin
    longint p[3], uv[2], nrm[3];
    if (rst) begin
      corner_idx <= 0;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) begin
          corner_pos[i][j] = 0;
          corner_nrm[i][j] = 0;
        end
        corner_uv[i][0] = 0;
        corner_uv[i][1] = 0;
      end
    end else if (in_valid && !in_stall) begin
      p[0] = $signed(pos_x); p[1] = $signed(pos_y); p[2] = $signed(pos_z);
      uv[0] = $signed(tex_u); uv[1] = $signed(tex_v);
      nrm[0] = $signed(norm_x); nrm[1] = $signed(norm_y); nrm[2] = $signed(norm_z);
      if (corner_idx < 2) begin
        for (int j = 0; j < 3; j++) begin
          corner_pos[corner_idx][j] = p[j];
          corner_nrm[corner_idx][j] = nrm[j];
        end
        corner_uv[corner_idx][0] = uv[0];
        corner_uv[corner_idx][1] = uv[1];
        corner_idx <= corner_idx + 1;
      end else begin
        predict_triangle(p, uv, nrm);
        corner_idx <= 0;
      end
    end
  end

  // Output transfers: compare with the oldest expected basis.
  always @(posedge clk) begin
    basis_t got, want;
    if (rst) begin
      fail_count <= 0;
      basis_count <= 0;
    end else if (out_valid && !out_stall) begin
      got = '{tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate, last_of_triangle};
      basis_count <= basis_count + 1;
      if (expected_bases.size() == 0) begin
        if (fail_count < 10)
          $display("MISMATCH: unexpected result transfer %h", got);
        fail_count <= fail_count + 1;
      end else begin
        want = expected_bases.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display({"MISMATCH: tan %h %h %h bitan %h %h %h deg %b last %b, ",
                      "expected %h %h %h %h %h %h %b %b"},
                     got.tx, got.ty, got.tz, got.bx, got.by, got.bz, got.deg, got.last,
                     want.tx, want.ty, want.tz, want.bx, want.by, want.bz, want.deg,
                     want.last);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

[tb/sv/tangent_basis_generator_tb.sv]
// Top of the tangent basis generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tangent_basis_generator_tb;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [15:0] pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z;
  logic [15:0] tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z;
  logic        degenerate, last_of_triangle;
  int          fail_count, pending, basis_count;
  int          send_idle_pct, recv_stall_pct, cycles, vertices_sent;

  tangent_basis_generator dut (.*);

  tangent_basis_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one vertex and waits for its transfer, idling first at random.
  task automatic send_vertex(input logic [15:0] px, py, pz, u, v, nx, ny, nz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    tex_u <= u; tex_v <= v;
    norm_x <= nx; norm_y <= ny; norm_z <= nz;
    do @(posedge clk); while (in_stall);
    vertices_sent++;
  endtask

  function automatic logic [15:0] rand_range(input int lim);
    return 16'($signed($urandom_range(2 * lim)) - lim);
  endfunction

  // A random vertex, either well-formed and moderate or any bit pattern.
  task automatic send_random_vertex(input bit wild);
    if (wild)
      send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_vertex(rand_range(2048), rand_range(2048), rand_range(2048),
                  rand_range(8192), rand_range(8192),
                  rand_range(16384), rand_range(16384), rand_range(16384));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cycles = 0;
    vertices_sent = 0;
    {pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z} = '0;
    send_idle_pct = 26;
    recv_stall_pct = 81;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Plain right-angle triangle with normals along z.
    send_vertex(0, 0, 0, 0, 0, 0, 0, 16384);
    send_vertex(256, 0, 0, 4096, 0, 0, 0, 16384);
    send_vertex(0, 256, 0, 0, 4096, 0, 0, 16384);
    // Normal along the tangent, a zero normal and a non-unit normal.
    send_vertex(0, 0, 0, 0, 0, 100, -200, 30000);
    send_vertex(256, 0, 0, 4096, 0, 16384, 0, 0);
    send_vertex(0, 256, 0, 0, 4096, 0, 0, 0);
    // Zero determinant: all texture coordinates the same.
    send_vertex(0, 0, 0, 100, 100, 0, 0, 16384);
    send_vertex(256, 0, 0, 100, 100, 0, 0, 16384);
    send_vertex(0, 256, 0, 100, 100, 0, 0, 16384);
    // Zero raw tangent: all positions the same.
    send_vertex(77, 77, 77, 0, 0, 0, 16384, 0);
    send_vertex(77, 77, 77, 4096, 0, 0, 16384, 0);
    send_vertex(77, 77, 77, 0, 4096, 0, 16384, 0);
    // Field extremes.
    send_vertex(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, -16384, 0, 0);
    send_vertex(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0, 16384, 0);
    send_vertex(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 0, 0, -16384);
    // Mirrored texture mapping, so a negative determinant.
    send_vertex(0, 0, 0, 0, 0, 0, 0, -16384);
    send_vertex(256, 0, 0, 0, 4096, 0, 0, -16384);
    send_vertex(0, 256, 0, 4096, 0, 0, 0, -16384);

    // Random triangles, mostly well-formed, through three idling phases.
    for (int t = 0; t < 100; t++) begin
      if (t == 33) begin
        send_idle_pct = 81;
        recv_stall_pct = 26;
      end else if (t == 66) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (int k = 0; k < 3; k++) send_random_vertex($urandom_range(99) < 20);
    end
    in_valid <= 1'b0;

    // Drain: wait for all expected bases, then a short tail.
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);

    $display("Sent %0d vertices and checked %0d bases, including degenerate triangles,",
             vertices_sent, basis_count);
    $display("flipped handedness, field extremes and any-pattern noise under stalls.");
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
